// ----- src/windowed_running_minmax_macros.svh -----
// ----------------------------------------------------------------------------
// Windowed running min/max assertion macros
// Concurrent checks used by the windowed running min/max top level.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_RUNNING_MINMAX_MACROS_SVH
`define WINDOWED_RUNNING_MINMAX_MACROS_SVH
`ifndef SYNTHESIS
`define WRM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("windowed_running_minmax: same-cycle check failed");
`define WRM_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("windowed_running_minmax: next-cycle check failed");
`else
`define WRM_ASSERT_IMP(label, clk, rst, ante, cons)
`define WRM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- src/wrm_pkg.sv -----
// ----------------------------------------------------------------------------
// Windowed running min/max package
// Default widths and configuration register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wrm_pkg;

  localparam int DEF_TIME_BITS  = 32;
  localparam int DEF_VALUE_BITS = 32;

  localparam int WIN_BITS       = 32;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_WINDOW_LENGTH = 1'b0,
    CFG_TRACK_MINIMUM = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

// ----- src/wrm_in_if.sv -----
// ----------------------------------------------------------------------------
// Windowed running min/max sample channel
// Valid/ready channel carrying one sample beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wrm_in_if #(
  parameter int TIME_BITS  = wrm_pkg::DEF_TIME_BITS,
  parameter int VALUE_BITS = wrm_pkg::DEF_VALUE_BITS
);

  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [TIME_BITS-1:0]  sample_time;
  logic [VALUE_BITS-1:0] sample_value;

  modport source (
    output valid,
    input  ready,
    output op,
    output sample_time,
    output sample_value
  );

  modport sink (
    input  valid,
    output ready,
    input  op,
    input  sample_time,
    input  sample_value
  );

endinterface

`default_nettype wire

// ----- src/wrm_out_if.sv -----
// ----------------------------------------------------------------------------
// Windowed running min/max result channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wrm_out_if #(
  parameter int VALUE_BITS = wrm_pkg::DEF_VALUE_BITS
);

  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] best_value;

  modport source (
    output valid,
    input  ready,
    output best_value
  );

  modport sink (
    input  valid,
    output ready,
    input  best_value
  );

endinterface

`default_nettype wire

// ----- src/windowed_running_minmax.sv -----
// ----------------------------------------------------------------------------
// Windowed running min/max
// Three-slot windowed maximum/minimum estimator over timestamped samples.
// ----------------------------------------------------------------------------
// Samples enter on sample_ch (op, sample_time, sample_value); every sample beat
// gives exactly one beat on result_ch carrying the best value in the window.
// op = 1 loads all three slots with the sample; op = 0 is a running update.
// window_length and track_minimum are written on the cfg port (index 0 and 1);
// the user must write them only while no beat is in flight; the block itself does not enforce it.
// A sample accepted on sample_ch passes through the sample register and then
// the result register before it is presented on result_ch (two register stages).
// Throughput: one sample per cycle while result_ch does not stall; the slot update is a single pass of
// compares and subtractions on three slot registers between the two stages.
// When result_ch stalls, the result register holds, the sample register fills
// and sample_ch.ready drops only once both stages are occupied.
// Reset (rst, synchronous) empties both stages, clears all slots to zero and
// sets window_length to 0 and the mode to maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module windowed_running_minmax #(
  parameter int TIME_BITS  = wrm_pkg::DEF_TIME_BITS,
  parameter int VALUE_BITS = wrm_pkg::DEF_VALUE_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  wrm_in_if.sink                                sample_ch,
  wrm_out_if.source                             result_ch,
  input  wire logic                             cfg_we,
  input  wire logic [wrm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [wrm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

`include "windowed_running_minmax_macros.svh"

  localparam int CMP_BITS = (TIME_BITS > wrm_pkg::WIN_BITS) ? TIME_BITS : wrm_pkg::WIN_BITS;

  typedef struct packed {
    logic [TIME_BITS-1:0]  t;
    logic [VALUE_BITS-1:0] v;
  } slot_t;

  logic [wrm_pkg::WIN_BITS-1:0] window_length;
  logic                         track_minimum;

  slot_t slot [3];
  slot_t slot_next [3];

  logic                  s1_valid;
  logic                  s1_op;
  slot_t                 s1_sample;
  logic                  s1_fire;

  logic                  res_valid;
  logic [VALUE_BITS-1:0] res_value;

  logic [CMP_BITS-1:0]   win_ext;
  logic [CMP_BITS-1:0]   win_quarter;
  logic [CMP_BITS-1:0]   win_half;

  slot_t                 mid [3];
  logic [TIME_BITS-1:0]  dt_s2;
  logic [TIME_BITS-1:0]  dt_s0;
  logic [TIME_BITS-1:0]  dt_m1;
  logic                  restart;

  function automatic logic as_good(input logic minimum, input logic [VALUE_BITS-1:0] a,
                                   input logic [VALUE_BITS-1:0] b);
    return minimum ? (a <= b) : (a >= b);
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= '0;
      track_minimum <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == wrm_pkg::CFG_WINDOW_LENGTH) begin
        window_length <= cfg_data[wrm_pkg::WIN_BITS-1:0];
      end else if (cfg_index == wrm_pkg::CFG_TRACK_MINIMUM) begin
        track_minimum <= cfg_data[0];
      end
    end
  end

  assign s1_fire         = s1_valid && (!res_valid || result_ch.ready);
  assign sample_ch.ready = !s1_valid || s1_fire;

  // sample register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_ch.ready) begin
      s1_valid <= sample_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ch.ready && sample_ch.valid) begin
      s1_op       <= sample_ch.op;
      s1_sample.t <= sample_ch.sample_time;
      s1_sample.v <= sample_ch.sample_value;
    end
  end

  // slot update
  always_comb begin
    win_ext     = CMP_BITS'(window_length);
    win_quarter = win_ext >> 2;
    win_half    = win_ext >> 1;
    dt_s2       = s1_sample.t - slot[2].t;
    restart     = s1_op || as_good(track_minimum, s1_sample.v, slot[0].v) ||
                  (CMP_BITS'(dt_s2) > win_ext);

    mid[0] = slot[0];
    mid[1] = slot[1];
    mid[2] = slot[2];
    if (as_good(track_minimum, s1_sample.v, slot[1].v)) begin
      mid[1] = s1_sample;
      mid[2] = s1_sample;
    end else if (as_good(track_minimum, s1_sample.v, slot[2].v)) begin
      mid[2] = s1_sample;
    end

    dt_s0 = s1_sample.t - mid[0].t;
    dt_m1 = s1_sample.t - mid[1].t;

    slot_next[0] = mid[0];
    slot_next[1] = mid[1];
    slot_next[2] = mid[2];
    if (restart) begin
      slot_next[0] = s1_sample;
      slot_next[1] = s1_sample;
      slot_next[2] = s1_sample;
    end else if (CMP_BITS'(dt_s0) > win_ext) begin
      if (CMP_BITS'(dt_m1) > win_ext) begin
        slot_next[0] = mid[2];
        slot_next[1] = s1_sample;
        slot_next[2] = s1_sample;
      end else begin
        slot_next[0] = mid[1];
        slot_next[1] = mid[2];
        slot_next[2] = s1_sample;
      end
    end else if ((mid[1].t == mid[0].t) && (CMP_BITS'(dt_s0) > win_quarter)) begin
      slot_next[1] = s1_sample;
      slot_next[2] = s1_sample;
    end else if ((mid[2].t == mid[1].t) && (CMP_BITS'(dt_s0) > win_half)) begin
      slot_next[2] = s1_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        slot[i] <= '0;
      end
    end else if (s1_fire) begin
      for (int i = 0; i < 3; i++) begin
        slot[i] <= slot_next[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire) begin
      res_valid <= 1'b1;
    end else if (result_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_value <= slot_next[0].v;
    end
  end

  assign result_ch.valid      = res_valid;
  assign result_ch.best_value = res_value;

  `WRM_ASSERT_NXT(a_result_tracks_best, clk, rst, s1_fire, res_valid && (res_value == slot[0].v))
  `WRM_ASSERT_NXT(a_load_all_slots, clk, rst, s1_fire && s1_op, (slot[0] == slot[1]) && (slot[1] == slot[2]))
  `WRM_ASSERT_NXT(a_sample_held, clk, rst, s1_valid && !s1_fire, s1_valid)
  `WRM_ASSERT_IMP(a_ready_when_empty, clk, rst, !s1_valid, sample_ch.ready)

endmodule

`default_nettype wire

// ----- tb/sv/tb_windowed_running_minmax.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed running min/max testbench
// Drives timestamped samples through the valid/ready sample channel,
// predicts the windowed best value with a three-slot estimator of its own
// and checks every result beat in order. A directed table covers the edge
// cases. Random phases follow, each with its own window, mode and pacing.
// ----------------------------------------------------------------------------

module tb_windowed_running_minmax;

  typedef logic [wrm_pkg::DEF_TIME_BITS-1:0]  stamp_t;
  typedef logic [wrm_pkg::DEF_VALUE_BITS-1:0] level_t;

  typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_t;
  typedef enum int {PACE_FULL, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} pace_t;

  localparam bit OP_UPDATE = 1'b0;
  localparam bit OP_LOAD   = 1'b1;

  localparam int N_PHASES    = 8;
  localparam int PHASE_BEATS = 175;

  typedef struct {
    row_kind_t         kind;
    bit                op;
    wrm_pkg::cfg_reg_t cfg_idx;
    stamp_t            t;
    level_t            v;
    bit                fixed;
    level_t            want;
  } drow_t;

  logic clk;
  logic rst;
  logic cfg_we;
  wrm_pkg::cfg_reg_t cfg_index;
  logic [wrm_pkg::CFG_DATA_BITS-1:0] cfg_data;

  wrm_in_if  in_ch ();
  wrm_out_if out_ch ();

  windowed_running_minmax DUT (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (in_ch),
    .result_ch (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  stamp_t slot_stamp [3];
  level_t slot_level [3];
  stamp_t win_len;
  bit     min_mode;

  level_t best_q [$];
  int     src_idle_pct;
  int     snk_stall_pct;
  int     n_beats;
  int     n_checked;
  int     n_writes;
  int     n_fail;

  drow_t steps [25];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic bit ranks_above(input level_t a, input level_t b);
    return min_mode ? (a <= b) : (a >= b);
  endfunction

  function automatic void fill_slots(input stamp_t t, input level_t v);
    for (int i = 0; i < 3; i++) begin
      slot_stamp[i] = t;
      slot_level[i] = v;
    end
  endfunction

  function automatic void push_slot(input stamp_t t, input level_t v);
    slot_stamp[0] = slot_stamp[1];
    slot_level[0] = slot_level[1];
    slot_stamp[1] = slot_stamp[2];
    slot_level[1] = slot_level[2];
    slot_stamp[2] = t;
    slot_level[2] = v;
  endfunction

  function automatic level_t best_after(input bit op, input stamp_t t, input level_t v);
    stamp_t gap;
    stamp_t age;
    gap = t - slot_stamp[2];
    if (op == OP_LOAD) begin
      fill_slots(t, v);
    end else if (ranks_above(v, slot_level[0]) || gap > win_len) begin
      fill_slots(t, v);
    end else begin
      if (ranks_above(v, slot_level[1])) begin
        slot_stamp[1] = t;
        slot_level[1] = v;
        slot_stamp[2] = t;
        slot_level[2] = v;
      end else if (ranks_above(v, slot_level[2])) begin
        slot_stamp[2] = t;
        slot_level[2] = v;
      end
      age = t - slot_stamp[0];
      if (age > win_len) begin
        push_slot(t, v);
        age = t - slot_stamp[0];
        if (age > win_len) push_slot(t, v);
      end else if (slot_stamp[1] == slot_stamp[0] && age > (win_len >> 2)) begin
        slot_stamp[1] = t;
        slot_level[1] = v;
        slot_stamp[2] = t;
        slot_level[2] = v;
      end else if (slot_stamp[2] == slot_stamp[1] && age > (win_len >> 1)) begin
        slot_stamp[2] = t;
        slot_level[2] = v;
      end
    end
    return slot_level[0];
  endfunction

  task automatic send_beat(input bit op, input stamp_t t, input level_t v,
                           input bit fixed, input level_t want);
    level_t guess;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.sample_time  <= t;
    in_ch.sample_value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    guess = best_after(op, t, v);
    best_q.push_back(fixed ? want : guess);
    n_beats++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (best_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input wrm_pkg::cfg_reg_t idx,
                           input logic [wrm_pkg::CFG_DATA_BITS-1:0] d,
                           input bit last);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    if (last) cfg_we <= 1'b0;
    if (idx == wrm_pkg::CFG_WINDOW_LENGTH) win_len = d;
    else min_mode = d[0];
    n_writes++;
  endtask

  task automatic set_pace(input pace_t pace);
    src_idle_pct  = (pace == PACE_SRC_IDLE)  ? 84 : (pace == PACE_BOTH) ? 22 : 0;
    snk_stall_pct = (pace == PACE_SNK_STALL) ? 84 : (pace == PACE_BOTH) ? 22 : 0;
  endtask

  // result side: random back-pressure and in-order check
  always @(posedge clk) begin
    level_t exp_best;
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_checked++;
      if (best_q.size() == 0) begin
        $error("best_value beat with nothing expected: got %0h", out_ch.best_value);
        n_fail++;
      end else begin
        exp_best = best_q.pop_front();
        if (out_ch.best_value !== exp_best) begin
          $error("best_value mismatch: expected %0h, got %0h", exp_best,
                 out_ch.best_value);
          n_fail++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    stamp_t now_t;
    stamp_t step;
    stamp_t pick;
    level_t base;
    level_t v;
    bit     op;
    int     sel;

    rst                <= 1'b1;
    in_ch.valid        <= 1'b0;
    in_ch.op           <= OP_UPDATE;
    in_ch.sample_time  <= '0;
    in_ch.sample_value <= '0;
    cfg_we             <= 1'b0;
    cfg_index          <= wrm_pkg::CFG_WINDOW_LENGTH;
    cfg_data           <= '0;
    fill_slots('0, '0);
    win_len   = '0;
    min_mode  = 1'b0;
    n_beats   = 0;
    n_checked = 0;
    n_writes  = 0;
    n_fail    = 0;
    set_pace(PACE_FULL);

    steps = '{
      '{ROW_SAMPLE, OP_UPDATE, wrm_pkg::CFG_WINDOW_LENGTH, 32'd5, 32'd100, 1'b1, 32'd100},
      '{ROW_SAMPLE, OP_UPDATE, wrm_pkg::CFG_WINDOW_LENGTH, 32'd5, 32'd50, 1'b1, 32'd100},
      '{ROW_SAMPLE, OP_UPDATE, wrm_pkg::CFG_WINDOW_LENGTH, 32'd6, 32'd50, 1'b1, 32'd50},
      '{ROW_SAMPLE, OP_LOAD, wrm_pkg::CFG_WINDOW_LENGTH, 32'd0, 32'd0, 1'b1, 32'd0},
      '{ROW_SAMPLE, OP_LOAD, wrm_pkg::CFG_WINDOW_LENGTH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
        32'hFFFF_FFFF},
      '{ROW_SAMPLE, OP_UPDATE, wrm_pkg::CFG_WINDOW_LENGTH, 32'd0, 32'd0, 1'b1, 32'd0},
      '{ROW_WRITE, OP_UPDATE, wrm_pkg::CFG_TRACK_MINIMUM, 32'd0, 32'd1, 1'b0, 32'd0},
      '{ROW_SAMPLE, OP_LOAD, wrm_pkg::CFG_WINDOW_LENGTH, 32'd0, 32'd0, 1'b1, 32'd0},
      '{ROW_SAMPLE, OP_UPDATE, wrm_pkg::CFG_WINDOW_LENGTH, 32'd1, 32'd7, 1'b1, 32'd7},
      '{ROW_WRITE, OP_UPDATE, wrm_pkg::CFG_WINDOW_LENGTH, 32'd0, 32'd100, 1'b0, 32'd0},
      '{ROW_SAMPLE, OP_LOAD, wrm_pkg::CFG_WINDOW_LENGTH, 32'd0, 32'd0, 1'b1, 32'd0},
      '{ROW_SAMPLE, OP_UPDATE, wrm_pkg::CFG_WINDOW_LENGTH, 32'd10, 32'd5, 1'b1, 32'd0},
      '{ROW_SAMPLE, OP_UPDATE, wrm_pkg::CFG_WINDOW_LENGTH, 32'd200, 32'd9, 1'b1, 32'd9},
      '{ROW_SAMPLE, OP_UPDATE, wrm_pkg::CFG_WINDOW_LENGTH, 32'd210, 32'd20, 1'b0, 32'd0},
      '{ROW_SAMPLE, OP_UPDATE, wrm_pkg::CFG_WINDOW_LENGTH, 32'd240, 32'd15, 1'b0, 32'd0},
      '{ROW_SAMPLE, OP_UPDATE, wrm_pkg::CFG_WINDOW_LENGTH, 32'd260, 32'd12, 1'b0, 32'd0},
      '{ROW_SAMPLE, OP_UPDATE, wrm_pkg::CFG_WINDOW_LENGTH, 32'd320, 32'd30, 1'b0, 32'd0},
      '{ROW_WRITE, OP_UPDATE, wrm_pkg::CFG_TRACK_MINIMUM, 32'd0, 32'd0, 1'b0, 32'd0},
      '{ROW_SAMPLE, OP_UPDATE, wrm_pkg::CFG_WINDOW_LENGTH, 32'd330, 32'd11, 1'b0, 32'd0},
      '{ROW_SAMPLE, OP_UPDATE, wrm_pkg::CFG_WINDOW_LENGTH, 32'd335, 32'd40, 1'b0, 32'd0},
      '{ROW_WRITE, OP_UPDATE, wrm_pkg::CFG_WINDOW_LENGTH, 32'd0, 32'hFFFF_FFFF, 1'b0, 32'd0},
      '{ROW_SAMPLE, OP_UPDATE, wrm_pkg::CFG_WINDOW_LENGTH, 32'd0, 32'd5, 1'b0, 32'd0},
      '{ROW_SAMPLE, OP_UPDATE, wrm_pkg::CFG_WINDOW_LENGTH, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'd0},
      '{ROW_SAMPLE, OP_LOAD, wrm_pkg::CFG_WINDOW_LENGTH, 32'h1234_5678, 32'hA5A5_A5A5, 1'b1,
        32'hA5A5_A5A5},
      '{ROW_SAMPLE, OP_UPDATE, wrm_pkg::CFG_WINDOW_LENGTH, 32'h1234_5679, 32'hFFFF_FFFF, 1'b1,
        32'hFFFF_FFFF}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[k]) begin
      if (steps[k].kind == ROW_WRITE) begin
        drain();
        write_reg(steps[k].cfg_idx, steps[k].v, 1'b1);
      end else begin
        send_beat(steps[k].op, steps[k].t, steps[k].v, steps[k].fixed, steps[k].want);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      case (p)
        0:       pick = '0;
        1:       pick = 32'hFFFF_FFFF;
        2:       pick = 32'd1;
        3, 5:    pick = $urandom;
        default: pick = $urandom_range(8, 4000);
      endcase
      write_reg(wrm_pkg::CFG_WINDOW_LENGTH, pick, 1'b0);
      write_reg(wrm_pkg::CFG_TRACK_MINIMUM, {31'd0, p[1] ^ p[0]}, 1'b1);
      set_pace(pace_t'(p % 4));
      now_t = $urandom;
      base  = $urandom;
      for (int i = 0; i < PHASE_BEATS; i++) begin
        // hold the sender until the pipeline is empty
        if (i == 60) drain();
        sel = $urandom_range(0, 99);
        if (sel < 55)      step = $urandom_range(0, win_len >> 2);
        else if (sel < 80) step = $urandom_range(win_len >> 2, win_len >> 1) + 1;
        else if (sel < 93) step = $urandom_range(win_len >> 1, win_len) + 1;
        else if (sel < 97) step = $urandom;
        else               step = '0;
        now_t = now_t + step;
        base  = base + $urandom_range(0, 16) - 8;
        sel   = $urandom_range(0, 99);
        if (sel < 70)      v = base + $urandom_range(0, 200) - 100;
        else if (sel < 80) v = $urandom;
        else if (sel < 85) v = '0;
        else if (sel < 90) v = '1;
        else               v = base;
        op = ($urandom_range(0, 99) < 3) ? OP_LOAD : OP_UPDATE;
        send_beat(op, now_t, v, 1'b0, '0);
      end
    end

    drain();
    repeat (4) @(posedge clk);

    $display("Run covered %0d sample beats across %0d register writes, four pacing modes.",
             n_beats, n_writes);
    $display("Result beats checked: %0d, mismatches: %0d", n_checked, n_fail);
    if (n_fail == 0 && best_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
